[sv/ptm_pkg.sv]
// Shared types, constants and helpers for the page table mapper.
package ptm_pkg;

    // Walk sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDATA,
        S_WALK,
        S_EVAL
    } t_state;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_VIRT_MIS  = 2'd1;
    localparam logic [1:0] ST_PHYS_MIS  = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Request kinds carried on tuser.
    localparam logic REQ_MAP  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int FRAME_W           = 40;
    localparam int FLAGS_W           = 12;
    localparam int ENTRY_W           = 64;
    localparam int IN_DATA_W         = 144;
    localparam int OUT_DATA_W        = 72;

    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [ENTRY_W-1:0] t_entry;

    // Builds a table entry: frame in bits 51..12, flags below, present bit set.
    function automatic t_entry make_entry(input t_frame frame,
                                          input logic [FLAGS_W-1:0] flags);
        make_entry = {12'd0, frame, flags} | 64'd1;
    endfunction

endpackage

[sv/ptm_ram.sv]
// Generic single-port-write, registered-read memory.
module ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/four_level_page_table_mapper_unit.sv]
// Four-level page table mapper: top level with walk sequencer and table memory.
// After reset the block clears its table memory, one word a cycle, before the
// first item is taken. A read request issues its table-memory read when it is
// taken, and the read data is registered as the result in S_RDATA. A map request
// walks each page through three dependent table-memory reads, each a read in
// S_WALK and an evaluation in S_EVAL with a possible write, plus one leaf write in
// S_WALK, all on the single memory port. One item is in work at a time, and the
// next is taken once the result transfer has completed.
module four_level_page_table_mapper_unit #(
    parameter int POOL_TABLES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write: pool_base_frame.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [39:0]  i_cfg_data,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: virt_addr[47:0], phys_addr[99:48], page_count[115:100],
    // entry_flags[127:116], table_index[131:128], entry_index[140:132], zeros
    input  logic [143:0] i_s_tdata,
    // tuser: req_type[0]
    input  logic         i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: status[1:0], entry_value[65:2], tables_used[70:66], zero[71]
    output logic [71:0]  o_m_tdata
);

    localparam int TW    = $clog2(POOL_TABLES);
    localparam int DEPTH = POOL_TABLES * ptm_pkg::ENTRIES_PER_TABLE;
    localparam int AW    = TW + ptm_pkg::IDX_W;
    localparam int NW    = $clog2(POOL_TABLES + 1);

    ptm_pkg::t_state r_state, n_state;
    logic [TW-1:0]   r_t, n_t;
    logic [1:0]      r_lvl, n_lvl;
    logic [35:0]     r_vpage, n_vpage;
    ptm_pkg::t_frame r_pframe, n_pframe;
    logic [15:0]     r_cnt, n_cnt;
    logic [11:0]     r_flags, n_flags;
    logic [1:0]      r_status, n_status;
    logic [NW-1:0]   r_nft, n_nft;
    ptm_pkg::t_frame r_base;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_oval, n_oval;
    logic [71:0]     r_odata, n_odata;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    ptm_pkg::t_entry       ram_wdata, ram_rdata;

    logic [8:0]            lvl_idx;
    ptm_pkg::t_frame       child;
    logic [47:0]           in_va;
    logic [51:0]           in_pa;
    logic [15:0]           in_cnt;
    logic [3:0]            in_ti;
    logic [8:0]            in_ei;
    logic                  in_xfer;

    ptm_ram #(.WIDTH(ptm_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request field unpacking.
    assign in_va   = i_s_tdata[47:0];
    assign in_pa   = i_s_tdata[99:48];
    assign in_cnt  = i_s_tdata[115:100];
    assign in_ti   = i_s_tdata[131:128];
    assign in_ei   = i_s_tdata[140:132];
    assign in_xfer = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ptm_pkg::S_IDLE) && !r_oval;
    assign o_m_tvalid  = r_oval;
    assign o_m_tdata   = r_odata;

    // Nine index bits for the current level.
    always_comb begin
        case (r_lvl)
            2'd0:    lvl_idx = r_vpage[35:27];
            2'd1:    lvl_idx = r_vpage[26:18];
            2'd2:    lvl_idx = r_vpage[17:9];
            default: lvl_idx = r_vpage[8:0];
        endcase
    end

    // Pool table named by a present link.
    assign child = ram_rdata[51:12] - r_base;

    // State register and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_nft   <= NW'(1);
            r_base  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_nft   <= n_nft;
            r_oval  <= n_oval;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // Walk payload registers.
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_lvl    <= n_lvl;
        r_vpage  <= n_vpage;
        r_pframe <= n_pframe;
        r_cnt    <= n_cnt;
        r_flags  <= n_flags;
        r_status <= n_status;
        r_odata  <= n_odata;
    end

    // Next state, memory accesses and result.
    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_lvl     = r_lvl;
        n_vpage   = r_vpage;
        n_pframe  = r_pframe;
        n_cnt     = r_cnt;
        n_flags   = r_flags;
        n_status  = r_status;
        n_nft     = r_nft;
        n_clr     = r_clr;
        n_oval    = r_oval && !i_m_tready;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = {r_t, lvl_idx};
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = {r_t, lvl_idx};

        unique case (r_state)
            ptm_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ptm_pkg::S_IDLE;
                end
            end
            ptm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_s_tuser == ptm_pkg::REQ_READ) begin
                        if (32'(in_ti) < POOL_TABLES) begin
                            ram_re    = 1'b1;
                            ram_raddr = {TW'(in_ti), in_ei};
                            n_state   = ptm_pkg::S_RDATA;
                        end else begin
                            n_oval  = 1'b1;
                            n_odata = {1'b0, 5'(r_nft), 64'd0, ptm_pkg::ST_OK};
                        end
                    end else begin
                        n_status = ptm_pkg::ST_OK;
                        if (in_cnt != 16'd0) begin
                            if (in_va[11:0] != 12'd0) begin
                                n_status = ptm_pkg::ST_VIRT_MIS;
                            end else if (in_pa[11:0] != 12'd0) begin
                                n_status = ptm_pkg::ST_PHYS_MIS;
                            end
                        end
                        n_vpage  = in_va[47:12];
                        n_pframe = in_pa[51:12];
                        n_cnt    = in_cnt;
                        n_flags  = i_s_tdata[127:116];
                        n_t      = '0;
                        n_lvl    = 2'd0;
                        if (in_cnt == 16'd0) begin
                            n_oval  = 1'b1;
                            n_odata = {1'b0, 5'(r_nft), 64'd0, ptm_pkg::ST_OK};
                        end else begin
                            n_state = ptm_pkg::S_WALK;
                        end
                    end
                end
            end
            ptm_pkg::S_RDATA: begin
                n_oval  = 1'b1;
                n_odata = {1'b0, 5'(r_nft), ram_rdata, ptm_pkg::ST_OK};
                n_state = ptm_pkg::S_IDLE;
            end
            ptm_pkg::S_WALK: begin
                if (r_lvl == 2'd3) begin
                    // Leaf entry, then on to the next page.
                    ram_we    = 1'b1;
                    ram_wdata = ptm_pkg::make_entry(r_pframe, r_flags);
                    n_cnt     = r_cnt - 16'd1;
                    n_vpage   = r_vpage + 36'd1;
                    n_pframe  = r_pframe + 40'd1;
                    n_t       = '0;
                    n_lvl     = 2'd0;
                    if (r_cnt == 16'd1) begin
                        n_oval  = 1'b1;
                        n_odata = {1'b0, 5'(r_nft), 64'd0, r_status};
                        n_state = ptm_pkg::S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = ptm_pkg::S_EVAL;
                end
            end
            ptm_pkg::S_EVAL: begin
                n_state = ptm_pkg::S_WALK;
                n_lvl   = r_lvl + 2'd1;
                if (ram_rdata[0]) begin
                    // Follow an existing link if it names an allocated table.
                    if (child >= 40'(r_nft)) begin
                        n_oval  = 1'b1;
                        n_odata = {1'b0, 5'(r_nft), 64'd0, ptm_pkg::ST_EXHAUSTED};
                        n_state = ptm_pkg::S_IDLE;
                    end else begin
                        n_t = child[TW-1:0];
                    end
                end else if (32'(r_nft) >= POOL_TABLES) begin
                    n_oval  = 1'b1;
                    n_odata = {1'b0, 5'(r_nft), 64'd0, ptm_pkg::ST_EXHAUSTED};
                    n_state = ptm_pkg::S_IDLE;
                end else begin
                    // Allocate a fresh table and link it.
                    ram_we    = 1'b1;
                    ram_wdata = ptm_pkg::make_entry(r_base + 40'(r_nft), r_flags);
                    n_t       = r_nft[TW-1:0];
                    n_nft     = r_nft + NW'(1);
                end
            end
            default: begin
                n_state = ptm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/ptm_checker.sv]
// Port-level checks for the page table mapper, bound to the top level.
module ptm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata
);

    logic r_pend_read;

    // Remember the kind of the last accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_read <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_pend_read <= i_s_tuser;
        end
    end

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No new request is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("request taken while result pending");

    // The root table is always counted.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[70:66] != 5'd0)
        else $error("tables_used is zero");

    // Read requests always report ok.
    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_pend_read |-> o_m_tdata[1:0] == 2'd0)
        else $error("read returned nonzero status");

endmodule

bind four_level_page_table_mapper_unit ptm_checker u_ptm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
